@@ rtl/core/tsrf_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_pkg
// Shared types, constants and CRC helpers for the sensor reading filter.
// ----------------------------------------------------------------------------
package tsrf_pkg;

  localparam int unsigned SensorSlots = 8;
  localparam int unsigned SlotW       = (SensorSlots > 1) ? $clog2(SensorSlots) : 1;
  localparam int unsigned IdxW        = 3;
  localparam int unsigned MagW        = 16;
  localparam logic [MagW-1:0] LimitReset = 16'd80;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // resolution codes, bits 6:5 of the configuration byte
  localparam logic [1:0] Res9Bit  = 2'b00;
  localparam logic [1:0] Res10Bit = 2'b01;
  localparam logic [1:0] Res11Bit = 2'b10;
  localparam logic [1:0] Res12Bit = 2'b11;

  localparam logic [7:0] CrcPoly = 8'h8C;

  typedef struct packed {
    logic [IdxW-1:0] sensor;
    logic            first;
    logic            crc_ok;
    logic            negative;
    logic [MagW-1:0] magnitude;
  } item_t;

  // bitwise CRC-8 over ROM bytes 0..6, LSB first; elaboration use only
  function automatic logic [7:0] crc8_serial(logic [55:0] data);
    logic [7:0] crc;
    logic       mix;
    crc = '0;
    for (int i = 0; i < 56; i++) begin
      mix = crc[0] ^ data[i];
      crc = crc >> 1;
      if (mix) begin
        crc = crc ^ CrcPoly;
      end
    end
    return crc;
  endfunction

  // the CRC is linear: each output bit is the parity of a fixed subset of data bits
  function automatic logic [7:0][55:0] crc8_masks();
    logic [7:0][55:0] m;
    logic [7:0]       c;
    m = '0;
    for (int i = 0; i < 56; i++) begin
      c = crc8_serial(56'd1 << i);
      for (int j = 0; j < 8; j++) begin
        m[j][i] = c[j];
      end
    end
    return m;
  endfunction

  localparam logic [7:0][55:0] CrcMask = crc8_masks();

endpackage
`default_nettype wire

@@ rtl/core/tsrf_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_in_if / tsrf_out_if
// Valid/ready channels carrying sensor readouts in and filter results out.
// ----------------------------------------------------------------------------
interface tsrf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  sensor_index;
  logic [63:0] rom_code;
  logic [7:0]  temp_low_byte;
  logic [7:0]  temp_high_byte;
  logic [7:0]  resolution_byte;
  logic        first_round;

  modport source (output valid, sensor_index, rom_code, temp_low_byte, temp_high_byte,
                  resolution_byte, first_round, input ready);
  modport sink   (input valid, sensor_index, rom_code, temp_low_byte, temp_high_byte,
                  resolution_byte, first_round, output ready);
endinterface

interface tsrf_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_sensor;
  logic        crc_ok;
  logic        reading_negative;
  logic [15:0] reading_magnitude;
  logic        accepted;
  logic [15:0] filtered_magnitude;

  modport source (output valid, out_sensor, crc_ok, reading_negative, reading_magnitude,
                  accepted, filtered_magnitude, input ready);
  modport sink   (input valid, out_sensor, crc_ok, reading_negative, reading_magnitude,
                  accepted, filtered_magnitude, output ready);
endinterface
`default_nettype wire

@@ rtl/core/tsrf_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_front
// Accepts readouts, checks the ROM CRC and forms sign and masked magnitude.
// ----------------------------------------------------------------------------
module tsrf_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  tsrf_in_if.sink              in_i,
  output tsrf_pkg::item_t      item_o,
  output logic                 item_valid_o,
  input  wire logic            item_ready_i
);
  import tsrf_pkg::*;

  logic            valid_q;
  item_t           item_q, item_d;
  logic [7:0]      crc;
  logic [15:0]     raw;
  logic [MagW-1:0] mag;
  logic            crc_ok;
  logic            take;

  always_comb begin
    for (int j = 0; j < 8; j++) begin
      crc[j] = ^(in_i.rom_code[55:0] & CrcMask[j]);
    end
  end

  assign crc_ok = (crc == in_i.rom_code[63:56]);
  assign raw    = {in_i.temp_high_byte, in_i.temp_low_byte};

  always_comb begin
    // 16-bit negation also covers the most negative reading (gives 32768)
    mag = raw[15] ? (~raw + 16'd1) : raw;
    case (in_i.resolution_byte[6:5])
      Res9Bit:  mag[2:0] = 3'b000;
      Res10Bit: mag[1:0] = 2'b00;
      Res11Bit: mag[0]   = 1'b0;
      Res12Bit: mag      = mag;
      default:  mag      = mag;
    endcase
  end

  always_comb begin
    item_d.sensor    = in_i.sensor_index;
    item_d.first     = in_i.first_round;
    item_d.crc_ok    = crc_ok;
    item_d.negative  = crc_ok & raw[15];
    item_d.magnitude = crc_ok ? mag : '0;
  end

  assign in_i.ready = !valid_q || item_ready_i;
  assign take       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= item_d;
    end
  end

  assign item_o       = item_q;
  assign item_valid_o = valid_q;

endmodule
`default_nettype wire

@@ rtl/core/tsrf_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_queue
// Short FIFO between the classify front and the filter back.
// ----------------------------------------------------------------------------
module tsrf_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire tsrf_pkg::item_t push_item_i,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  output tsrf_pkg::item_t      pop_item_o,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i
);
  import tsrf_pkg::*;

  item_t            mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_q, rd_q;
  logic [QCntW-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = (cnt_q != QCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_item_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_q + QPtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/tsrf_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_back
// Per-sensor rate limit filter: compare against the kept value, update, report.
// ----------------------------------------------------------------------------
module tsrf_back (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire tsrf_pkg::item_t       item_i,
  input  wire logic                  item_valid_i,
  output logic                       item_ready_o,
  input  wire logic [tsrf_pkg::MagW-1:0] limit_i,
  tsrf_out_if.source                 out_o
);
  import tsrf_pkg::*;

  logic [MagW-1:0] kept_q [SensorSlots];
  logic [SlotW-1:0] slot;
  logic            in_slots;
  logic [MagW-1:0] kept;
  logic [MagW:0]   diff;
  logic [MagW-1:0] abs_diff;
  logic            in_range;
  logic            acc;
  logic            pop;

  logic            out_v_q;
  logic [IdxW-1:0] sensor_q;
  logic            crc_ok_q, neg_q, acc_q;
  logic [MagW-1:0] mag_q, filt_q;

  assign in_slots = (32'(item_i.sensor) < SensorSlots);
  assign slot     = SlotW'(item_i.sensor);
  assign kept     = in_slots ? kept_q[slot] : '0;

  // |mag - kept| <= limit
  assign diff     = {1'b0, item_i.magnitude} - {1'b0, kept};
  assign abs_diff = diff[MagW] ? (~diff[MagW-1:0] + MagW'(1)) : diff[MagW-1:0];
  assign in_range = (abs_diff <= limit_i);
  assign acc      = item_i.crc_ok && in_slots && (item_i.first || in_range);

  assign item_ready_o = !out_v_q || out_o.ready;
  assign pop          = item_valid_i && item_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
      for (int s = 0; s < SensorSlots; s++) begin
        kept_q[s] <= '0;
      end
    end else begin
      if (item_ready_o) begin
        out_v_q <= item_valid_i;
      end
      if (pop && acc) begin
        kept_q[slot] <= item_i.magnitude;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      sensor_q <= item_i.sensor;
      crc_ok_q <= item_i.crc_ok;
      neg_q    <= item_i.negative;
      mag_q    <= item_i.magnitude;
      acc_q    <= acc;
      filt_q   <= acc ? item_i.magnitude : kept;
    end
  end

  assign out_o.valid              = out_v_q;
  assign out_o.out_sensor         = sensor_q;
  assign out_o.crc_ok             = crc_ok_q;
  assign out_o.reading_negative   = neg_q;
  assign out_o.reading_magnitude  = mag_q;
  assign out_o.accepted           = acc_q;
  assign out_o.filtered_magnitude = filt_q;

endmodule
`default_nettype wire

@@ rtl/core/temp_sensor_reading_filter_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// temp_sensor_reading_filter_unit
// Thermometer readout checker and per-sensor rate limit filter.
// ----------------------------------------------------------------------------
// The unit takes one readout word per clock while the result channel does
// not stall it and returns one result word per readout, in order. A readout
// passes a registered front stage (ROM CRC-8 check, sign/magnitude and
// resolution masking), a two-entry queue and the filter stage, whose
// read-modify-write of the per-sensor kept value is done as the item is
// popped; that stage sets the rate of one word per cycle. A readout is held
// in the front register, then in the queue, then in the result register.
// Write change_limit only while the unit is idle; it resets to 80.
module temp_sensor_reading_filter_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tsrf_in_if.sink          in_i,
  tsrf_out_if.source       out_o,
  input  wire logic        change_limit_we_i,
  input  wire logic [15:0] change_limit_i
);
  import tsrf_pkg::*;

  logic [MagW-1:0] limit_q;
  item_t           f_item, q_item;
  logic            f_valid, f_ready, q_valid, q_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (change_limit_we_i) begin
      limit_q <= change_limit_i;
    end
  end

  tsrf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (f_item),
    .item_valid_o (f_valid),
    .item_ready_i (f_ready)
  );

  tsrf_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (f_item),
    .push_valid_i (f_valid),
    .push_ready_o (f_ready),
    .pop_item_o   (q_item),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready)
  );

  tsrf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (q_item),
    .item_valid_i (q_valid),
    .item_ready_o (q_ready),
    .limit_i      (limit_q),
    .out_o        (out_o)
  );

endmodule
`default_nettype wire

@@ rtl/core/tsrf_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_checker
// Port-level checks on the result channel of the reading filter.
// ----------------------------------------------------------------------------
module tsrf_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic        crc_ok_i,
  input wire logic        negative_i,
  input wire logic [15:0] magnitude_i,
  input wire logic        accepted_i,
  input wire logic [15:0] filtered_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(magnitude_i) && $stable(filtered_i))
    else $error("result word changed while stalled");

  // CRC failure blanks the reading and never updates
  a_crc_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !crc_ok_i |-> !negative_i && magnitude_i == 16'd0 && !accepted_i)
    else $error("bad CRC word carries a reading");

  // an accepted reading becomes the stored value
  a_acc_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && accepted_i |-> crc_ok_i && filtered_i == magnitude_i)
    else $error("accepted reading not stored");

  // magnitude never exceeds 32768
  a_mag_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !magnitude_i[15] || magnitude_i[14:0] == 15'd0)
    else $error("magnitude out of range");

endmodule

bind temp_sensor_reading_filter_unit tsrf_checker u_tsrf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .crc_ok_i    (out_o.crc_ok),
  .negative_i  (out_o.reading_negative),
  .magnitude_i (out_o.reading_magnitude),
  .accepted_i  (out_o.accepted),
  .filtered_i  (out_o.filtered_magnitude)
);
`default_nettype wire

@@ tb/tsrf_filter_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tsrf_filter_checker
// Watches the readout and result channels of the sensor reading filter. It
// tracks change_limit writes, predicts each result from the accepted readout
// (ROM CRC-8, sign/magnitude, resolution masking, per-sensor rate limit) and
// compares every field of each result word against the oldest prediction.
// ----------------------------------------------------------------------------
module tsrf_filter_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  tsrf_in_if                in_w,
  tsrf_out_if               out_w,
  input  wire logic         change_limit_we_i,
  input  wire logic [15:0]  change_limit_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);
  import tsrf_pkg::*;

  localparam int unsigned PrintCap = 100;

  typedef struct packed {
    logic [IdxW-1:0] sensor;
    logic            crc_ok;
    logic            negative;
    logic [MagW-1:0] magnitude;
    logic            accepted;
    logic [MagW-1:0] filtered;
  } filter_result_t;

  logic [MagW-1:0] kept_mag [SensorSlots];
  logic [15:0]     limit_q;
  filter_result_t  pending_results [$];
  int unsigned     mismatch_count;

  assign mismatches_o = mismatch_count;

  // Dallas CRC-8, reflected poly, byte 0 first, each byte LSB first
  function automatic logic [7:0] rom_crc(logic [63:0] rom);
    logic [7:0] crc;
    logic [7:0] data;
    crc = '0;
    for (int b = 0; b < 7; b++) begin
      data = rom[8*b +: 8];
      for (int k = 0; k < 8; k++) begin
        if (crc[0] ^ data[0]) begin
          crc = (crc >> 1) ^ CrcPoly;
        end else begin
          crc = crc >> 1;
        end
        data = data >> 1;
      end
    end
    return crc;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    mismatch_count++;
    if (mismatch_count <= PrintCap) begin
      $display("%0t: %s got %h want %h", $time, what, got, want);
    end
  endtask

  task automatic predict_filter_step();
    filter_result_t r;
    logic [15:0]    raw;
    logic [16:0]    mag;
    int             slot;
    int             diff;
    int             lim;
    bit             in_slots;
    r        = '0;
    raw      = {in_w.temp_high_byte, in_w.temp_low_byte};
    slot     = int'(in_w.sensor_index);
    in_slots = slot < SensorSlots;
    r.sensor = in_w.sensor_index;
    r.crc_ok = rom_crc(in_w.rom_code) == in_w.rom_code[63:56];
    if (in_slots) begin
      r.filtered = kept_mag[slot];
    end
    if (r.crc_ok) begin
      r.negative = raw[15];
      mag = raw[15] ? ({1'b0, ~raw} + 17'd1) : {1'b0, raw};
      // low bits are undefined below 12 bit resolution
      case (in_w.resolution_byte[6:5])
        Res9Bit:  mag[2:0] = '0;
        Res10Bit: mag[1:0] = '0;
        Res11Bit: mag[0]   = 1'b0;
        Res12Bit: ;
        default:  ;
      endcase
      r.magnitude = mag[15:0];
      if (in_slots) begin
        diff = int'(mag) - int'(kept_mag[slot]);
        lim  = int'(limit_q);
        if (in_w.first_round || (diff <= lim && diff >= -lim)) begin
          kept_mag[slot] = mag[15:0];
          r.accepted     = 1'b1;
        end
        r.filtered = kept_mag[slot];
      end
    end
    pending_results.push_back(r);
  endtask

  task automatic compare_result();
    filter_result_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("unexpected result word", {13'd0, out_w.out_sensor}, 16'd0);
      return;
    end
    want = pending_results.pop_front();
    if (out_w.out_sensor !== want.sensor)
      report_mismatch("out_sensor", {13'd0, out_w.out_sensor}, {13'd0, want.sensor});
    if (out_w.crc_ok !== want.crc_ok)
      report_mismatch("crc_ok", {15'd0, out_w.crc_ok}, {15'd0, want.crc_ok});
    if (out_w.reading_negative !== want.negative)
      report_mismatch("reading_negative", {15'd0, out_w.reading_negative},
                      {15'd0, want.negative});
    if (out_w.reading_magnitude !== want.magnitude)
      report_mismatch("reading_magnitude", out_w.reading_magnitude, want.magnitude);
    if (out_w.accepted !== want.accepted)
      report_mismatch("accepted", {15'd0, out_w.accepted}, {15'd0, want.accepted});
    if (out_w.filtered_magnitude !== want.filtered)
      report_mismatch("filtered_magnitude", out_w.filtered_magnitude, want.filtered);
  endtask

  initial mismatch_count = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SensorSlots; s++) begin
        kept_mag[s] = '0;
      end
      limit_q = LimitReset;
      pending_results.delete();
      pending_o <= 0;
    end else begin
      if (change_limit_we_i) begin
        limit_q = change_limit_i;
      end
      if (in_w.valid && in_w.ready) begin
        predict_filter_step();
      end
      if (out_w.valid && out_w.ready) begin
        compare_result();
      end
      pending_o <= pending_results.size();
    end
  end

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the sensor reading filter. Sends a directed set of
// readouts (resolution masks, sign extremes, CRC failures, limit edges) and
// then random readouts, mostly CRC-correct and close to the last value of the
// sensor, under several change_limit settings. Input bursts and output stalls
// are random; the checker beside the block does all comparison.
// ----------------------------------------------------------------------------
module testbench;
  import tsrf_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned PhaseWords  = 80;

  logic        clk;
  logic        rst_n;
  logic        limit_we;
  logic [15:0] limit_val;
  logic [15:0] cur_limit;
  logic [15:0] last_raw [SensorSlots];
  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count;
  int          burst_left;

  tsrf_in_if  in_ch ();
  tsrf_out_if out_ch ();

  temp_sensor_reading_filter_unit dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_i              (in_ch),
    .out_o             (out_ch),
    .change_limit_we_i (limit_we),
    .change_limit_i    (limit_val)
  );

  tsrf_filter_checker checker_u (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_w              (in_ch),
    .out_w             (out_ch),
    .change_limit_we_i (limit_we),
    .change_limit_i    (limit_val),
    .mismatches_o      (mismatches),
    .pending_o         (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial cycle_count = 0;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver: rotates between always ready, random and periodic stalls
  initial begin
    int unsigned tick;
    tick = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tick++;
      case ((tick / 97) % 4)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 9) < 7);
        2: out_ch.ready <= ((tick % 8) < 3);
        default: out_ch.ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // append the CRC byte, serial form over the 56 body bits
  function automatic logic [63:0] seal_rom(logic [55:0] body);
    logic [7:0] crc;
    logic       fb;
    crc = '0;
    for (int i = 0; i < 56; i++) begin
      fb  = crc[0] ^ body[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ CrcPoly;
    end
    return {crc, body};
  endfunction

  function automatic logic [63:0] good_rom();
    return seal_rom(56'({$urandom, $urandom}));
  endfunction

  function automatic logic [63:0] broken_rom();
    logic [7:0] flip;
    flip = 8'($urandom_range(1, 255));
    return good_rom() ^ {flip, 56'd0};
  endfunction

  // holds valid until the word is taken, then maybe opens a gap
  task automatic send_readout(input logic [2:0] idx, input logic [63:0] rom,
                              input logic [15:0] raw, input logic [7:0] res,
                              input logic first);
    int gap;
    in_ch.valid           <= 1'b1;
    in_ch.sensor_index    <= idx;
    in_ch.rom_code        <= rom;
    in_ch.temp_low_byte   <= raw[7:0];
    in_ch.temp_high_byte  <= raw[15:8];
    in_ch.resolution_byte <= res;
    in_ch.first_round     <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    repeat (4) @(posedge clk);
    while (pending != 0) @(posedge clk);
    // margin for the last word to leave the pipe
    repeat (6) @(posedge clk);
  endtask

  task automatic write_limit(input logic [15:0] value);
    limit_we  <= 1'b1;
    limit_val <= value;
    @(posedge clk);
    limit_we  <= 1'b0;
    cur_limit = value;
  endtask

  task automatic random_readout();
    logic [2:0]  idx;
    logic [63:0] rom;
    logic [15:0] raw;
    logic        first;
    bit          good;
    bit          near;
    int          choice;
    int          span;
    int          delta;
    idx    = 3'($urandom_range(0, 7));
    good   = $urandom_range(0, 99) < 85;
    rom    = good ? good_rom() : broken_rom();
    first  = ($urandom_range(0, 19) == 0);
    choice = $urandom_range(0, 99);
    near   = 1'b0;
    if (choice < 55) begin
      span  = int'(cur_limit) * 2 + 16;
      if (span > 4096) span = 4096;
      delta = int'($urandom_range(0, 2 * span)) - span;
      raw   = 16'(int'(last_raw[idx]) + delta);
      near  = (delta <= int'(cur_limit)) && (delta >= -int'(cur_limit));
    end else if (choice < 65) begin
      // same magnitude, opposite sign
      raw = -last_raw[idx];
    end else if (choice < 72) begin
      raw = last_raw[idx];
    end else begin
      raw = 16'($urandom);
    end
    if (good && (near || first)) last_raw[idx] = raw;
    send_readout(idx, rom, raw, 8'($urandom_range(0, 255)), first);
  endtask

  initial begin
    logic [15:0] phase_limits [5];
    rst_n                 <= 1'b0;
    limit_we              <= 1'b0;
    limit_val             <= '0;
    in_ch.valid           <= 1'b0;
    in_ch.sensor_index    <= '0;
    in_ch.rom_code        <= '0;
    in_ch.temp_low_byte   <= '0;
    in_ch.temp_high_byte  <= '0;
    in_ch.resolution_byte <= '0;
    in_ch.first_round     <= 1'b0;
    cur_limit  = LimitReset;
    burst_left = 1;
    for (int s = 0; s < SensorSlots; s++) last_raw[s] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limit of 80
    send_readout(3'd0, seal_rom('0), 16'h0000, 8'h7F, 1'b1);
    send_readout(3'd0, good_rom(), 16'h0050, 8'h60, 1'b0);   // change equals limit
    send_readout(3'd0, good_rom(), 16'h00A1, 8'h60, 1'b0);   // one past limit
    send_readout(3'd0, good_rom(), 16'hFFB0, 8'h60, 1'b0);   // -80 vs stored 80
    send_readout(3'd1, good_rom(), 16'h8000, 8'h60, 1'b1);   // most negative
    send_readout(3'd2, good_rom(), 16'h7FFF, 8'h00, 1'b1);
    send_readout(3'd2, good_rom(), 16'h7FFF, 8'h20, 1'b0);
    send_readout(3'd2, good_rom(), 16'h7FFF, 8'h40, 1'b0);
    send_readout(3'd3, good_rom(), 16'hFFFF, 8'h9F, 1'b1);
    send_readout(3'd3, good_rom(), 16'hFFFF, 8'hFF, 1'b0);
    send_readout(3'd4, broken_rom(), 16'h0190, 8'h60, 1'b1); // bad CRC stores nothing
    send_readout(3'd4, good_rom(), 16'h0040, 8'h60, 1'b0);
    send_readout(3'd5, broken_rom(), 16'hFFFF, 8'hFF, 1'b0);
    send_readout(3'd7, good_rom(), 16'h0550, 8'h7F, 1'b1);
    send_readout(3'd6, seal_rom({56{1'b1}}), 16'hFC90, 8'h60, 1'b1);
    drain_results();

    write_limit(16'd0);
    send_readout(3'd0, good_rom(), 16'h0050, 8'h60, 1'b0);
    send_readout(3'd0, good_rom(), 16'h0051, 8'h60, 1'b0);
    send_readout(3'd0, good_rom(), 16'h0057, 8'h00, 1'b0);   // masked back to 80
    drain_results();

    write_limit(16'h8000);
    send_readout(3'd1, good_rom(), 16'h0000, 8'h60, 1'b0);
    send_readout(3'd1, good_rom(), 16'h8000, 8'h60, 1'b0);
    drain_results();

    write_limit(16'hFFFF);
    send_readout(3'd2, good_rom(), 16'h0123, 8'h60, 1'b0);
    drain_results();

    last_raw[0] = 16'h0050;
    last_raw[2] = 16'h0123;
    last_raw[3] = 16'hFFFF;
    last_raw[4] = 16'h0040;
    last_raw[6] = 16'hFC90;
    last_raw[7] = 16'h0550;

    phase_limits[0] = 16'($urandom_range(1, 300));
    phase_limits[1] = 16'd0;
    phase_limits[2] = 16'h8000;
    phase_limits[3] = 16'hFFFF;
    phase_limits[4] = 16'($urandom_range(0, 65535));
    for (int p = 0; p < 5; p++) begin
      write_limit(phase_limits[p]);
      repeat (PhaseWords) random_readout();
      drain_results();
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
